// ----- rtl/core/pcgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Probe capture gain sequencer package
// Phase, command, probe source and config codes and reset values for the core.
// ----------------------------------------------------------------------------
package pcgs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FADE    = 3'd1,
        PH_PROBE   = 3'd2,
        PH_TAIL    = 3'd3,
        PH_CAPT    = 3'd4,
        PH_ANAL    = 3'd5,
        PH_RAMP    = 3'd6
    } phase_t;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ARM    = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_RESUME = 3'd3;
    localparam logic [2:0] MODE_START  = 3'd4;

    localparam logic [1:0] PROBE_NONE    = 2'd0;
    localparam logic [1:0] PROBE_SILENCE = 2'd1;
    localparam logic [1:0] PROBE_SWEEP   = 2'd2;

    localparam logic [1:0] CFG_SWEEP_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_CAPTURE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MUTE_STEP      = 2'd2;
    localparam logic [1:0] CFG_RAMP_STEP      = 2'd3;

    localparam int SWEEP_LENGTH_RESET   = 48000;
    localparam int CAPTURE_LENGTH_RESET = 96000;
    localparam int MUTE_STEP_RESET      = 68;
    localparam int RAMP_STEP_RESET      = 68;

endpackage

// ----- rtl/core/pcgs_gain_apply.sv -----
// ----------------------------------------------------------------------------
// Gain multiplier
// Multiplies a signed sample by an unsigned fixed point gain and floors the
// product back to the sample width with an arithmetic shift.
// ----------------------------------------------------------------------------
module pcgs_gain_apply #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic        [GAIN_FRAC_BITS:0]   gain,
    output logic signed [SAMPLE_BITS-1:0]    gained
);

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_FRAC_BITS + 2;

    logic signed [GAIN_FRAC_BITS+1:0] gain_s;
    logic signed [PROD_BITS-1:0]      product;
    logic signed [PROD_BITS-1:0]      shifted;

    assign gain_s  = $signed({1'b0, gain});
    assign product = PROD_BITS'(sample) * PROD_BITS'(gain_s);
    assign shifted = product >>> GAIN_FRAC_BITS;
    assign gained  = shifted[SAMPLE_BITS-1:0];

endmodule

// ----- rtl/core/probe_capture_gain_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Probe capture gain sequencer core
// Per-sample sequencer for one measurement run: probe source selection,
// capture addressing and output gain fade, mute and ramp.
// ----------------------------------------------------------------------------
// The input channel carries one transaction per audio sample tick or per
// command (arm, cancel, resume, start analysis). Every transaction produces
// exactly one result transaction on the output channel.
// An accepted transaction is held in an input register; once the output
// side advances, the sequencer logic and the two gain multipliers evaluate
// it against the run state and load the result register, which presents
// the result. One transaction is taken in every cycle while the output
// side keeps up. The run state is updated in the same cycle the result
// register loads, so consecutive transactions see each other's effect.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more; only then does in_stall rise.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at the
// next clock edge and are meant to happen while no transaction is in flight.
// Reset clears both pipeline stages, sets the phase to idle, the gain to
// unity and the counters to zero, and restores the default register values.
// ----------------------------------------------------------------------------
module probe_capture_gain_sequencer_core
    import pcgs_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int INDEX_BITS     = 20,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [((INDEX_BITS > GAIN_FRAC_BITS) ? INDEX_BITS : GAIN_FRAC_BITS + 1)-1:0]
                                          cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    mode,
    input  logic signed [SAMPLE_BITS-1:0] out_left,
    input  logic signed [SAMPLE_BITS-1:0] out_right,
    input  logic signed [SAMPLE_BITS-1:0] chain_left,
    input  logic signed [SAMPLE_BITS-1:0] chain_right,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] gained_left,
    output logic signed [SAMPLE_BITS-1:0] gained_right,
    output logic [1:0]                    probe_kind,
    output logic [INDEX_BITS-1:0]         probe_index,
    output logic                          capture_write,
    output logic [INDEX_BITS-1:0]         capture_index,
    output logic signed [SAMPLE_BITS-1:0] capture_left,
    output logic signed [SAMPLE_BITS-1:0] capture_right,
    output logic [2:0]                    phase_code,
    output logic [GAIN_FRAC_BITS:0]       gain_now,
    output logic [INDEX_BITS-1:0]         captured_count
);

    localparam int G = GAIN_FRAC_BITS + 1;
    localparam logic [G-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    // Configuration registers.
    logic [INDEX_BITS-1:0] sweep_length_reg;
    logic [INDEX_BITS-1:0] capture_length_reg;
    logic [G-1:0]          mute_step_reg;
    logic [G-1:0]          ramp_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_length_reg   <= INDEX_BITS'(SWEEP_LENGTH_RESET);
            capture_length_reg <= INDEX_BITS'(CAPTURE_LENGTH_RESET);
            mute_step_reg      <= G'(MUTE_STEP_RESET);
            ramp_step_reg      <= G'(RAMP_STEP_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SWEEP_LENGTH:   sweep_length_reg   <= cfg_data[INDEX_BITS-1:0];
                CFG_CAPTURE_LENGTH: capture_length_reg <= cfg_data[INDEX_BITS-1:0];
                CFG_MUTE_STEP:      mute_step_reg      <= cfg_data[G-1:0];
                CFG_RAMP_STEP:      ramp_step_reg      <= cfg_data[G-1:0];
                default:            ;
            endcase
        end
    end

    // Input register stage.
    logic                          in_valid_reg;
    logic [2:0]                    mode_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic signed [SAMPLE_BITS-1:0] chain_left_reg;
    logic signed [SAMPLE_BITS-1:0] chain_right_reg;

    logic out_valid_reg;
    logic advance;
    logic in_accept;
    logic fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign fire      = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg        <= mode;
            out_left_reg    <= out_left;
            out_right_reg   <= out_right;
            chain_left_reg  <= chain_left;
            chain_right_reg <= chain_right;
        end
    end

    // Run state.
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [G-1:0]          gain_reg;
    logic [G-1:0]          gain_next;
    logic [INDEX_BITS-1:0] probe_position_reg;
    logic [INDEX_BITS-1:0] probe_position_next;
    logic [INDEX_BITS-1:0] written_count_reg;
    logic [INDEX_BITS-1:0] written_count_next;

    // Intermediate tick results.
    logic                  is_tick;
    phase_t                phase_after_probe;
    phase_t                phase_after_capture;
    logic [INDEX_BITS-1:0] position_inc;
    logic [INDEX_BITS-1:0] count_inc;
    logic                  tick_capture;
    logic [G-1:0]          tick_gain;
    phase_t                tick_phase;
    logic [G-1:0]          room;

    assign is_tick = (mode_reg == MODE_TICK);

    always_comb
    begin
        position_inc = (probe_position_reg != INDEX_MAX) ?
                       probe_position_reg + 1'b1 : probe_position_reg;
        count_inc    = written_count_reg + 1'b1;

        phase_after_probe = phase_reg;
        if (phase_reg == PH_PROBE && position_inc >= sweep_length_reg)
        begin
            phase_after_probe = PH_TAIL;
        end

        tick_capture        = 1'b0;
        phase_after_capture = phase_after_probe;
        if (phase_after_probe == PH_PROBE || phase_after_probe == PH_TAIL)
        begin
            tick_capture = (written_count_reg < capture_length_reg);
            if ((tick_capture ? count_inc : written_count_reg) >= capture_length_reg)
            begin
                phase_after_capture = PH_CAPT;
            end
        end

        room       = (gain_reg < UNITY) ? UNITY - gain_reg : '0;
        tick_phase = phase_after_capture;
        case (phase_after_capture)
            PH_IDLE:
            begin
                tick_gain = UNITY;
            end
            PH_FADE:
            begin
                tick_gain = (gain_reg > mute_step_reg) ? gain_reg - mute_step_reg : '0;
                if (tick_gain == '0)
                begin
                    tick_phase = PH_PROBE;
                end
            end
            PH_RAMP:
            begin
                tick_gain = (ramp_step_reg >= room) ? UNITY : gain_reg + ramp_step_reg;
                if (tick_gain >= UNITY)
                begin
                    tick_phase = PH_IDLE;
                end
            end
            default:
            begin
                tick_gain = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next          = phase_reg;
        gain_next           = gain_reg;
        probe_position_next = probe_position_reg;
        written_count_next  = written_count_reg;
        case (mode_reg)
            MODE_TICK:
            begin
                phase_next = tick_phase;
                gain_next  = tick_gain;
                if (phase_reg == PH_PROBE || phase_reg == PH_TAIL)
                begin
                    probe_position_next = position_inc;
                end
                if (tick_capture)
                begin
                    written_count_next = count_inc;
                end
            end
            MODE_ARM:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    probe_position_next = '0;
                    written_count_next  = '0;
                    phase_next          = PH_FADE;
                end
            end
            MODE_CANCEL:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_RAMP;
                end
            end
            MODE_RESUME:
            begin
                if (phase_reg == PH_ANAL)
                begin
                    phase_next = PH_RAMP;
                end
            end
            MODE_START:
            begin
                if (phase_reg == PH_CAPT)
                begin
                    phase_next = PH_ANAL;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_RAMP;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            gain_reg           <= UNITY;
            probe_position_reg <= '0;
            written_count_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            gain_reg           <= gain_next;
            probe_position_reg <= probe_position_next;
            written_count_reg  <= written_count_next;
        end
    end

    // Result fields.
    logic signed [SAMPLE_BITS-1:0] mult_left;
    logic signed [SAMPLE_BITS-1:0] mult_right;

    pcgs_gain_apply #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_left (
        .sample (out_left_reg),
        .gain   (tick_gain),
        .gained (mult_left)
    );

    pcgs_gain_apply #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_right (
        .sample (out_right_reg),
        .gain   (tick_gain),
        .gained (mult_right)
    );

    logic signed [SAMPLE_BITS-1:0] gained_left_next;
    logic signed [SAMPLE_BITS-1:0] gained_right_next;
    logic [1:0]                    probe_kind_next;
    logic [INDEX_BITS-1:0]         probe_index_next;
    logic                          capture_write_next;
    logic [INDEX_BITS-1:0]         capture_index_next;
    logic signed [SAMPLE_BITS-1:0] capture_left_next;
    logic signed [SAMPLE_BITS-1:0] capture_right_next;

    always_comb
    begin
        gained_left_next   = '0;
        gained_right_next  = '0;
        probe_kind_next    = PROBE_NONE;
        probe_index_next   = '0;
        capture_write_next = 1'b0;
        capture_index_next = '0;
        capture_left_next  = '0;
        capture_right_next = '0;
        if (is_tick)
        begin
            gained_left_next  = mult_left;
            gained_right_next = mult_right;
            if (phase_reg == PH_FADE)
            begin
                probe_kind_next = PROBE_SILENCE;
            end
            else if (phase_reg == PH_PROBE || phase_reg == PH_TAIL)
            begin
                if (probe_position_reg < sweep_length_reg)
                begin
                    probe_kind_next  = PROBE_SWEEP;
                    probe_index_next = probe_position_reg;
                end
                else
                begin
                    probe_kind_next = PROBE_SILENCE;
                end
            end
            if (tick_capture)
            begin
                capture_write_next = 1'b1;
                capture_index_next = written_count_reg;
                capture_left_next  = chain_left_reg;
                capture_right_next = chain_right_reg;
            end
        end
    end

    // Result register stage.
    logic signed [SAMPLE_BITS-1:0] gained_left_reg;
    logic signed [SAMPLE_BITS-1:0] gained_right_reg;
    logic [1:0]                    probe_kind_reg;
    logic [INDEX_BITS-1:0]         probe_index_reg;
    logic                          capture_write_reg;
    logic [INDEX_BITS-1:0]         capture_index_reg;
    logic signed [SAMPLE_BITS-1:0] capture_left_reg;
    logic signed [SAMPLE_BITS-1:0] capture_right_reg;
    logic [2:0]                    phase_code_reg;
    logic [G-1:0]                  gain_now_reg;
    logic [INDEX_BITS-1:0]         captured_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            gained_left_reg    <= gained_left_next;
            gained_right_reg   <= gained_right_next;
            probe_kind_reg     <= probe_kind_next;
            probe_index_reg    <= probe_index_next;
            capture_write_reg  <= capture_write_next;
            capture_index_reg  <= capture_index_next;
            capture_left_reg   <= capture_left_next;
            capture_right_reg  <= capture_right_next;
            phase_code_reg     <= phase_next;
            gain_now_reg       <= gain_next;
            captured_count_reg <= written_count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign gained_left    = gained_left_reg;
    assign gained_right   = gained_right_reg;
    assign probe_kind     = probe_kind_reg;
    assign probe_index    = probe_index_reg;
    assign capture_write  = capture_write_reg;
    assign capture_index  = capture_index_reg;
    assign capture_left   = capture_left_reg;
    assign capture_right  = capture_right_reg;
    assign phase_code     = phase_code_reg;
    assign gain_now       = gain_now_reg;
    assign captured_count = captured_count_reg;

    // Assertions.
    a_capture_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && capture_write |-> captured_count == capture_index + 1'b1)
        else $error("captured count does not follow the capture address");

    a_capture_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && capture_write |->
            (phase_code == PH_PROBE || phase_code == PH_TAIL || phase_code == PH_CAPT))
        else $error("capture write outside the capture phases");

    a_sweep_muted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && probe_kind == PROBE_SWEEP |-> gain_now == '0)
        else $error("output not muted while the sweep plays");

    a_idle_unity: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick && phase_reg == PH_IDLE |=> gain_reg == UNITY)
        else $error("idle tick did not restore unity gain");

endmodule
